// ===== rtl/sbcp_pkg.sv =====
// Shared types and constants for the sinogram bin to crystal pair block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sbcp_pkg;

    // Index width of crystal positions on the ring
    localparam int INDEX_BITS = 10;

    // Field widths of the request and the configuration registers
    localparam int ELEM_W   = 10;
    localparam int VIEW_W   = 10;
    localparam int SUB_W    = 4;
    localparam int NELEM_W  = 10;
    localparam int MASH_W   = 5;
    localparam int RING_W   = 10;
    localparam int HEAD_W   = 6;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    // view*mash + sub, and the signed sums before the ring wrap
    localparam int BASE_W = VIEW_W + MASH_W;
    localparam int SUM_W  = BASE_W + 3;

    // Divisor head_crystals+1 and the partial remainder of the divider
    localparam int DIV_W = HEAD_W + 1;
    localparam int REM_W = HEAD_W + 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_N_ELEM        = 2'd0,
        CFG_MASH          = 2'd1,
        CFG_RING_CRYSTALS = 2'd2,
        CFG_HEAD_CRYSTALS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic [VIEW_W-1:0] view;
        logic [SUB_W-1:0]  sub;
    } t_req;

    typedef struct packed {
        logic [INDEX_BITS-1:0] crystal_a;
        logic [INDEX_BITS-1:0] crystal_b;
        logic                  in_gap;
        logic [INDEX_BITS-1:0] gapless_a;
        logic [INDEX_BITS-1:0] gapless_b;
    } t_rsp;

    // Crystal pair after the ring wrap
    typedef struct packed {
        logic [INDEX_BITS-1:0] a;
        logic [INDEX_BITS-1:0] b;
    } t_pair;

    // One lane of the division chain: original index, dividend bits still
    // to shift in, partial remainder, quotient so far
    typedef struct packed {
        logic [INDEX_BITS-1:0] x;
        logic [INDEX_BITS-1:0] sh;
        logic [REM_W-1:0]      rem;
        logic [INDEX_BITS-1:0] q;
    } t_lane;

    typedef struct packed {
        t_lane a;
        t_lane b;
    } t_div;

endpackage

`default_nettype wire

// ===== rtl/sinogram_bin_to_crystal_pair.sv =====
// Sinogram bin to crystal pair: top level with configuration registers,
// front end, division chain of INDEX_BITS cells and the output register.
// Stages: 3 front stages, INDEX_BITS cells and 1 output stage.
// Throughput: one request per cycle; each stage holds only while the next stalls.
// Reset: synchronous active-low; clears all valid bits and loads the register
// defaults (n_elem 344, mash 1, ring_crystals 504, head_crystals 8).
`default_nettype none

module sinogram_bin_to_crystal_pair import sbcp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_req                  i_req,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_rsp                       o_rsp
);

    logic [NELEM_W-1:0] r_n_elem;
    logic [MASH_W-1:0]  r_mash;
    logic [RING_W-1:0]  r_ring;
    logic [HEAD_W-1:0]  r_head;
    logic [DIV_W-1:0]   w_div;

    logic  w_front_valid, w_front_ready;
    t_pair w_pair;
    t_div  w_div_in;

    logic  w_cv [INDEX_BITS+1];
    logic  w_cr [INDEX_BITS+1];
    t_div  w_cd [INDEX_BITS+1];

    logic  r_out_valid;
    logic  w_out_ready;
    t_rsp  r_rsp, n_rsp;
    logic  w_gap_a, w_gap_b;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_elem <= NELEM_W'(344);
            r_mash   <= MASH_W'(1);
            r_ring   <= RING_W'(504);
            r_head   <= HEAD_W'(8);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_N_ELEM:        r_n_elem <= i_cfg_data[NELEM_W-1:0];
                CFG_MASH:          r_mash   <= i_cfg_data[MASH_W-1:0];
                CFG_RING_CRYSTALS: r_ring   <= i_cfg_data[RING_W-1:0];
                CFG_HEAD_CRYSTALS: r_head   <= i_cfg_data[HEAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_div = {1'b0, r_head} + DIV_W'(1);

    sbcp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_n_elem (r_n_elem),
        .i_mash   (r_mash),
        .i_ring   (r_ring),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_req    (i_req),
        .o_valid  (w_front_valid),
        .i_ready  (w_front_ready),
        .o_pair   (w_pair)
    );

    // Seed both division lanes
    always_comb begin
        w_div_in.a.x   = w_pair.a;
        w_div_in.a.sh  = w_pair.a;
        w_div_in.a.rem = '0;
        w_div_in.a.q   = '0;
        w_div_in.b.x   = w_pair.b;
        w_div_in.b.sh  = w_pair.b;
        w_div_in.b.rem = '0;
        w_div_in.b.q   = '0;
    end

    assign w_cv[0]       = w_front_valid;
    assign w_cd[0]       = w_div_in;
    assign w_front_ready = w_cr[0];

    // Division chain, one quotient bit per cell
    for (genvar k = 0; k < INDEX_BITS; k++) begin : g_cell
        sbcp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_div   (w_div),
            .i_valid (w_cv[k]),
            .o_ready (w_cr[k]),
            .i_data  (w_cd[k]),
            .o_valid (w_cv[k+1]),
            .i_ready (w_cr[k+1]),
            .o_data  (w_cd[k+1])
        );
    end

    // Gap test and gap removal from quotient and remainder
    always_comb begin
        w_gap_a = (DIV_W'(w_cd[INDEX_BITS].a.rem) == w_div - DIV_W'(1));
        w_gap_b = (DIV_W'(w_cd[INDEX_BITS].b.rem) == w_div - DIV_W'(1));
        n_rsp.crystal_a = w_cd[INDEX_BITS].a.x;
        n_rsp.crystal_b = w_cd[INDEX_BITS].b.x;
        n_rsp.in_gap    = w_gap_a || w_gap_b;
        if (w_gap_a || w_gap_b) begin
            n_rsp.gapless_a = '0;
            n_rsp.gapless_b = '0;
        end else begin
            n_rsp.gapless_a = w_cd[INDEX_BITS].a.x - w_cd[INDEX_BITS].a.q;
            n_rsp.gapless_b = w_cd[INDEX_BITS].b.x - w_cd[INDEX_BITS].b.q;
        end
    end

    // Output register
    assign w_out_ready      = !r_out_valid || i_ready;
    assign w_cr[INDEX_BITS] = w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_cv[INDEX_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// ===== rtl/sbcp_front.sv =====
// Front end: base product, the two crystal sums and the ring wrap, three stages.
// Depends on sbcp_pkg.
`default_nettype none

module sbcp_front import sbcp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [NELEM_W-1:0] i_n_elem,
    input  wire logic [MASH_W-1:0]  i_mash,
    input  wire logic [RING_W-1:0]  i_ring,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire t_req               i_req,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_pair                   o_pair
);

    logic                r_v1, r_v2, r_v3;
    logic                w_rdy1, w_rdy2, w_rdy3;
    logic [BASE_W-1:0]   r_base;
    logic [ELEM_W-1:0]   r_elem;
    logic [SUM_W-1:0]    r_raw_a, r_raw_b;
    logic [SUM_W-1:0]    n_raw_a, n_raw_b;
    logic [ELEM_W:0]     w_elem_up;
    logic [SUM_W-1:0]    w_ring;
    logic [INDEX_BITS-1:0] n_a, n_b;
    t_pair               r_pair;

    // Stage readiness, from the output side back
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_pair  = r_pair;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // Stage 1: base = view*mash + sub
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_base <= BASE_W'(i_req.view * i_mash) + BASE_W'(i_req.sub);
            r_elem <= i_req.elem;
        end
    end

    // Stage 2: raw sums in two's complement
    always_comb begin
        w_elem_up = {1'b0, r_elem} + (ELEM_W+1)'(1);
        n_raw_a = SUM_W'(r_base) + SUM_W'(r_elem[ELEM_W-1:1])
                - SUM_W'(i_n_elem[NELEM_W-1:2]);
        n_raw_b = SUM_W'(r_base) + SUM_W'(i_ring[RING_W-1:1])
                - SUM_W'(w_elem_up[ELEM_W:1]) + SUM_W'(i_n_elem[NELEM_W-1:2]);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_raw_a <= n_raw_a;
            r_raw_b <= n_raw_b;
        end
    end

    // Stage 3: one wrap step into the ring, then keep the index bits
    function automatic logic [INDEX_BITS-1:0] wrap(input logic [SUM_W-1:0] x,
                                                   input logic [SUM_W-1:0] r);
        logic [SUM_W-1:0] y;
        if (x[SUM_W-1]) begin
            y = x + r;
        end else if (x >= r) begin
            y = x - r;
        end else begin
            y = x;
        end
        return y[INDEX_BITS-1:0];
    endfunction

    assign w_ring = SUM_W'(i_ring);

    always_comb begin
        n_a = wrap(r_raw_a, w_ring);
        n_b = wrap(r_raw_b, w_ring);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_pair.a <= n_a;
            r_pair.b <= n_b;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sbcp_cell.sv =====
// One cell of the division chain: one restoring quotient bit for each crystal.
// Depends on sbcp_pkg.
`default_nettype none

module sbcp_cell import sbcp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [DIV_W-1:0] i_div,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_div             i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_div                  o_data
);

    logic r_valid;
    t_div r_data;
    t_div n_data;

    // Shift in the next dividend bit, subtract the divisor when it fits
    function automatic t_lane step(input t_lane l, input logic [DIV_W-1:0] d);
        t_lane            o;
        logic [REM_W-1:0] rs;
        logic             qb;
        rs = {l.rem[REM_W-2:0], l.sh[INDEX_BITS-1]};
        qb = (rs >= REM_W'(d));
        o.x   = l.x;
        o.sh  = {l.sh[INDEX_BITS-2:0], 1'b0};
        o.rem = qb ? (rs - REM_W'(d)) : rs;
        o.q   = {l.q[INDEX_BITS-2:0], qb};
        return o;
    endfunction

    always_comb begin
        n_data.a = step(i_data.a, i_div);
        n_data.b = step(i_data.b, i_div);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Hold while the neighbor stalls, else advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_sinogram_bin_to_crystal_pair.sv =====
// Testbench for sinogram_bin_to_crystal_pair: drives sinogram bins through a valid/ready
// channel, predicts each crystal pair in its own model and checks every response field.
// Depends on sbcp_pkg and the block's top module, and through it on sbcp_front and sbcp_cell.
`timescale 1ns / 1ps

module tb_sinogram_bin_to_crystal_pair;
    import sbcp_pkg::*;

    localparam int PIPE_LATENCY   = 14;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int BINS_PER_PHASE = 75;
    localparam int REQ_W          = $bits(t_req);

    // Kinds of register setting for the random phases
    typedef enum int {
        SET_DEFAULT,
        SET_SCANNER,
        SET_NOISE,
        SET_EXTREME
    } t_setting_kind;

    // One row of the directed table: either a full register setting or a bin
    typedef struct {
        bit                    is_setting;
        logic [CFG_DATA_W-1:0] n_elem_val;
        logic [CFG_DATA_W-1:0] mash_val;
        logic [CFG_DATA_W-1:0] ring_val;
        logic [CFG_DATA_W-1:0] head_val;
        t_req                  bin;
        bit                    known;
        t_rsp                  pair;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    t_req                  i_req;
    logic                  o_valid;
    logic                  i_ready;
    t_rsp                  o_rsp;

    sinogram_bin_to_crystal_pair dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp)
    );

    // Shadow copy of the configuration registers
    logic [NELEM_W-1:0] n_elem_cfg;
    logic [MASH_W-1:0]  mash_cfg;
    logic [RING_W-1:0]  ring_cfg;
    logic [HEAD_W-1:0]  head_cfg;

    t_rsp     pending_pairs[$];
    t_dir_row dir_rows[$];
    int       fail_count = 0;
    int       idle_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Crystal pair prediction
    // ------------------------------------------------------------------

    // Bring a position into the ring by one add or subtract, keep the index bits
    function automatic logic [INDEX_BITS-1:0] fold_into_ring(int x);
        int rc;
        rc = int'(ring_cfg);
        if (x < 0) begin
            x = x + rc;
        end else if (x >= rc) begin
            x = x - rc;
        end
        return x[INDEX_BITS-1:0];
    endfunction

    // Every (head_crystals+1)-th position is the gap after a head
    function automatic bit is_gap_slot(logic [INDEX_BITS-1:0] x);
        return ((int'(x) + 1) % (int'(head_cfg) + 1)) == 0;
    endfunction

    function automatic logic [INDEX_BITS-1:0] remove_gaps(logic [INDEX_BITS-1:0] x);
        int t;
        t = int'(x) - int'(x) / (int'(head_cfg) + 1);
        return t[INDEX_BITS-1:0];
    endfunction

    function automatic t_rsp crystal_pair_of(t_req r);
        int   base;
        int   quarter;
        int   half_ring;
        int   elem;
        t_rsp p;
        elem      = int'(r.elem);
        quarter   = int'(n_elem_cfg) / 4;
        half_ring = int'(ring_cfg) / 2;
        base      = int'(r.view) * int'(mash_cfg) + int'(r.sub);
        p.crystal_a = fold_into_ring(base + elem / 2 - quarter);
        p.crystal_b = fold_into_ring(base + half_ring - (elem + 1) / 2 + quarter);
        p.in_gap    = is_gap_slot(p.crystal_a) || is_gap_slot(p.crystal_b);
        p.gapless_a = p.in_gap ? '0 : remove_gaps(p.crystal_a);
        p.gapless_b = p.in_gap ? '0 : remove_gaps(p.crystal_b);
        return p;
    endfunction

    function automatic t_rsp make_pair(int a, int b, bit g, int ga, int gb);
        t_rsp p;
        p.crystal_a = a[INDEX_BITS-1:0];
        p.crystal_b = b[INDEX_BITS-1:0];
        p.in_gap    = g;
        p.gapless_a = ga[INDEX_BITS-1:0];
        p.gapless_b = gb[INDEX_BITS-1:0];
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    function automatic t_req make_bin(int e, int v, int s);
        t_req r;
        r.elem = e[ELEM_W-1:0];
        r.view = v[VIEW_W-1:0];
        r.sub  = s[SUB_W-1:0];
        return r;
    endfunction

    function automatic void add_bin(int e, int v, int s);
        t_dir_row row;
        row = '{default: '0};
        row.bin = make_bin(e, v, s);
        dir_rows.push_back(row);
    endfunction

    function automatic void add_known(int e, int v, int s, t_rsp p);
        t_dir_row row;
        row = '{default: '0};
        row.bin   = make_bin(e, v, s);
        row.known = 1'b1;
        row.pair  = p;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_setting(int n, int m, int r, int h);
        t_dir_row row;
        row = '{default: '0};
        row.is_setting = 1'b1;
        row.n_elem_val = n[CFG_DATA_W-1:0];
        row.mash_val   = m[CFG_DATA_W-1:0];
        row.ring_val   = r[CFG_DATA_W-1:0];
        row.head_val   = h[CFG_DATA_W-1:0];
        dir_rows.push_back(row);
    endfunction

    // Random bin: mostly inside the current geometry, the rest anywhere in the fields
    function automatic t_req pick_bin();
        t_req r;
        int   vmax;
        r.elem = ELEM_W'($urandom_range(2**ELEM_W - 1));
        r.view = VIEW_W'($urandom_range(2**VIEW_W - 1));
        r.sub  = SUB_W'($urandom_range(2**SUB_W - 1));
        if ($urandom_range(3) != 0) begin
            if (n_elem_cfg != 0) begin
                r.elem = ELEM_W'($urandom_range(int'(n_elem_cfg) - 1));
            end
            if (mash_cfg != 0) begin
                vmax   = int'(ring_cfg) / int'(mash_cfg);
                r.view = (vmax > 0) ? VIEW_W'($urandom_range(vmax - 1)) : '0;
                r.sub  = SUB_W'($urandom_range(int'(mash_cfg) - 1));
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Write one register; called at a falling edge, returns at the next one
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        case (idx)
            CFG_N_ELEM:        n_elem_cfg = d[NELEM_W-1:0];
            CFG_MASH:          mash_cfg   = d[MASH_W-1:0];
            CFG_RING_CRYSTALS: ring_cfg   = d[RING_W-1:0];
            CFG_HEAD_CRYSTALS: head_cfg   = d[HEAD_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_setting(logic [CFG_DATA_W-1:0] n, logic [CFG_DATA_W-1:0] m,
                                logic [CFG_DATA_W-1:0] r, logic [CFG_DATA_W-1:0] h);
        write_reg(CFG_N_ELEM, n);
        write_reg(CFG_MASH, m);
        write_reg(CFG_RING_CRYSTALS, r);
        write_reg(CFG_HEAD_CRYSTALS, h);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid and hold until every predicted pair has come out
    task automatic wait_pairs_out();
        i_valid <= 1'b0;
        while (pending_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Offer one bin and hold it until accepted; record the expected pair
    task automatic send_bin(t_req r, bit known, t_rsp want);
        i_valid <= 1'b1;
        i_req   <= r;
        do begin
            @(posedge i_clk);
        end while (o_ready !== 1'b1);
        pending_pairs.push_back(known ? want : crystal_pair_of(r));
        @(negedge i_clk);
    endtask

    task automatic pick_setting(t_setting_kind kind);
        int h;
        int heads;
        int r;
        int n;
        int m;
        case (kind)
            SET_DEFAULT: begin
                load_setting(10'd344, 10'd1, 10'd504, 10'd8);
            end
            SET_SCANNER: begin
                h     = $urandom_range(1, 63);
                heads = $urandom_range(2, 1023 / (h + 1));
                r     = heads * (h + 1);
                n     = $urandom_range(1, r);
                m     = $urandom_range(1, 16);
                // Junk in the unused upper data bits must be ignored
                load_setting(n[9:0], {5'($urandom_range(31)), m[4:0]}, r[9:0],
                             {4'($urandom_range(15)), h[5:0]});
            end
            SET_NOISE: begin
                load_setting(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                             10'($urandom_range(1023)), 10'($urandom_range(1023)));
            end
            default: begin
                if ($urandom_range(1) == 1) begin
                    load_setting(10'd1023, 10'd16, 10'd1023, 10'd63);
                end else begin
                    load_setting(10'd1, 10'd1, 10'd2, 10'd1);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Receiver stall pattern
    // ------------------------------------------------------------------
    int       ready_mode = 0;
    logic [7:0] mode_timer = '0;
    logic [7:0] stall_mask = 8'hFF;
    int       stall_left = 0;

    always @(negedge i_clk) begin
        mode_timer <= mode_timer + 8'd1;
        if (mode_timer == 8'd0) begin
            ready_mode <= $urandom_range(3);
            stall_mask <= 8'($urandom_range(255)) | 8'h01;
        end else begin
            stall_mask <= {stall_mask[6:0], stall_mask[7]};
        end
        case (ready_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(1));
            2: i_ready <= stall_mask[0];
            default: begin
                if (stall_left > 0) begin
                    stall_left <= stall_left - 1;
                    i_ready    <= 1'b0;
                end else if ($urandom_range(15) == 0) begin
                    stall_left <= $urandom_range(1, 30);
                    i_ready    <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Response checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_pairs.size() == 0) begin
                $error("unexpected response: crystal_a %0d crystal_b %0d",
                       o_rsp.crystal_a, o_rsp.crystal_b);
                fail_count++;
            end else begin
                want = pending_pairs.pop_front();
                if (o_rsp.crystal_a !== want.crystal_a) begin
                    $error("crystal_a: expected %0d, got %0d", want.crystal_a, o_rsp.crystal_a);
                    fail_count++;
                end
                if (o_rsp.crystal_b !== want.crystal_b) begin
                    $error("crystal_b: expected %0d, got %0d", want.crystal_b, o_rsp.crystal_b);
                    fail_count++;
                end
                if (o_rsp.in_gap !== want.in_gap) begin
                    $error("in_gap: expected %0d, got %0d", want.in_gap, o_rsp.in_gap);
                    fail_count++;
                end
                if (o_rsp.gapless_a !== want.gapless_a) begin
                    $error("gapless_a: expected %0d, got %0d", want.gapless_a, o_rsp.gapless_a);
                    fail_count++;
                end
                if (o_rsp.gapless_b !== want.gapless_b) begin
                    $error("gapless_b: expected %0d, got %0d", want.gapless_b, o_rsp.gapless_b);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run: count cycles with no request or response moving
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int   burst_left;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_N_ELEM;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_req      = '0;
        i_ready    = 1'b0;
        n_elem_cfg = 10'd344;
        mash_cfg   = 5'd1;
        ring_cfg   = 10'd504;
        head_cfg   = 6'd8;

        // Register defaults straight after reset
        add_known(0, 0, 0, make_pair(418, 338, 1'b0, 372, 301));
        add_known(188, 0, 0, make_pair(8, 244, 1'b1, 0, 0));
        add_bin(1023, 1023, 15);
        add_bin(1022, 0, 0);
        add_bin(0, 1022, 0);
        add_bin(0, 0, 15);
        add_bin(343, 503, 0);
        // Largest registers but for the mashing factor, which is 16
        add_setting(1023, 16, 1023, 63);
        add_bin(0, 0, 0);
        add_bin(1022, 63, 15);
        add_bin(1023, 1023, 15);
        add_bin(511, 32, 7);
        // Zero mashing factor
        add_setting(344, 0, 504, 8);
        add_bin(100, 900, 3);
        add_bin(0, 1023, 15);
        // Zero ring size: wrap has no effect, negative sums wrap in the index bits
        add_setting(344, 1, 0, 8);
        add_bin(0, 0, 0);
        add_bin(500, 100, 2);
        // Zero head size: every position is a gap
        add_setting(344, 1, 504, 0);
        add_known(0, 0, 0, make_pair(418, 338, 1'b1, 0, 0));
        add_bin(700, 300, 5);
        // Small registers, then sums far outside the ring
        add_setting(1, 1, 2, 1);
        add_known(0, 0, 0, make_pair(0, 1, 1'b1, 0, 0));
        add_bin(1, 1, 1);
        add_bin(1023, 1023, 15);
        // Defaults again, with junk above the mash and head fields
        add_setting(344, 'h3E1, 504, 'h3C8);
        add_known(0, 0, 0, make_pair(418, 338, 1'b0, 372, 301));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table back to back
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_setting) begin
                wait_pairs_out();
                load_setting(dir_rows[k].n_elem_val, dir_rows[k].mash_val,
                             dir_rows[k].ring_val, dir_rows[k].head_val);
            end else begin
                send_bin(dir_rows[k].bin, dir_rows[k].known, dir_rows[k].pair);
            end
        end

        // Random phases, each under a new register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_pairs_out();
            case (ph)
                0:       pick_setting(SET_DEFAULT);
                4, 8:    pick_setting(SET_NOISE);
                6, 9:    pick_setting(SET_EXTREME);
                default: pick_setting(SET_SCANNER);
            endcase
            burst_left = $urandom_range(1, 24);
            for (int n = 0; n < BINS_PER_PHASE; n++) begin
                // Phases 0 and 5 stream without sender gaps
                if (burst_left == 0) begin
                    if (ph != 0 && ph != 5) begin
                        i_valid <= 1'b0;
                        i_req   <= REQ_W'($urandom);
                        repeat ($urandom_range(1, 8)) @(negedge i_clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                send_bin(pick_bin(), 1'b0, '0);
                burst_left--;
            end
        end

        wait_pairs_out();
        repeat (3 * PIPE_LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sbcp_pkg.sv
rtl/sbcp_front.sv
rtl/sbcp_cell.sv
rtl/sinogram_bin_to_crystal_pair.sv
test/tb_sinogram_bin_to_crystal_pair.sv
